// ===== sv/uhv_pkg.sv =====
// ----------------------------------------------------------------------------
// uhv_pkg
// Shared types and constants for the URI host validator: payload structs,
// character class bundle, queue entry and result kind codes.
// ----------------------------------------------------------------------------
package uhv_pkg;

  // input transfer payload
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } in_data_t;

  // output transfer payload
  typedef struct packed {
    logic       valid_res;
    logic [2:0] host_kind;
  } out_data_t;

  // result kinds
  typedef enum logic [2:0] {
    KIND_INVALID = 3'd0,
    KIND_EMPTY   = 3'd1,
    KIND_IPV4    = 3'd2,
    KIND_IPV6    = 3'd3,
    KIND_FUTURE  = 3'd4,
    KIND_NAME    = 3'd5
  } kind_e;

  // character classes of one byte
  typedef struct packed {
    logic       is_digit;
    logic       is_hex;
    logic       is_unres;
    logic       is_sub;
    logic       is_colon;
    logic       is_dot;
    logic       is_pct;
    logic       is_v;
    logic [3:0] digit;
  } cls_t;

  // entry passed from classifier to recognizer
  typedef struct packed {
    cls_t cls;
    logic has_char;
    logic last;
  } entry_t;

endpackage

// ===== sv/uhv_classify.sv =====
// ----------------------------------------------------------------------------
// uhv_classify
// Front end: takes input transfers, sorts each byte into character classes
// and writes an entry into the queue.
// ----------------------------------------------------------------------------
module uhv_classify (
  input  logic             in_valid_i,
  input  uhv_pkg::in_data_t in_data_i,
  input  logic             full_i,
  output logic             in_ready_o,
  output logic             push_o,
  output uhv_pkg::entry_t  entry_o
);
  import uhv_pkg::*;

  logic [7:0] c;
  logic       alpha;
  logic       sub;

  assign c = in_data_i.ch;
  assign alpha = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);

  always_comb begin
    case (c)
      8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29,
      8'h2a, 8'h2b, 8'h2c, 8'h3b, 8'h3d: sub = 1'b1;
      default: sub = 1'b0;
    endcase
  end

  always_comb begin
    entry_o.cls.is_digit = (c >= 8'h30 && c <= 8'h39);
    entry_o.cls.is_hex   = entry_o.cls.is_digit || (c >= 8'h61 && c <= 8'h66) ||
                           (c >= 8'h41 && c <= 8'h46);
    entry_o.cls.is_unres = entry_o.cls.is_digit || alpha || c == 8'h2d ||
                           c == 8'h2e || c == 8'h5f || c == 8'h7e;
    entry_o.cls.is_sub   = sub;
    entry_o.cls.is_colon = (c == 8'h3a);
    entry_o.cls.is_dot   = (c == 8'h2e);
    entry_o.cls.is_pct   = (c == 8'h25);
    entry_o.cls.is_v     = (c == 8'h76);
    entry_o.cls.digit    = 4'(c - 8'h30);
    entry_o.has_char     = in_data_i.has_char;
    entry_o.last         = in_data_i.last;
  end

  // empty items that are not last change nothing, so they are dropped here
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i && (in_data_i.has_char || in_data_i.last);

endmodule

// ===== sv/uhv_fifo.sv =====
// ----------------------------------------------------------------------------
// uhv_fifo
// Short queue of classified entries between front end and recognizer.
// ----------------------------------------------------------------------------
module uhv_fifo #(
  parameter int Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  uhv_pkg::entry_t wdata_i,
  input  logic            pop_i,
  output uhv_pkg::entry_t rdata_o,
  output logic            empty_o,
  output logic            full_o
);
  import uhv_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == FullCnt);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== sv/uhv_recognize.sv =====
// ----------------------------------------------------------------------------
// uhv_recognize
// Back end: ipv4, ipv6, ipvfuture and reg-name recognizers take one entry per
// cycle if the output register can take a last one, which holds the result.
// ----------------------------------------------------------------------------
module uhv_recognize (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  uhv_pkg::entry_t  entry_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output uhv_pkg::out_data_t out_data_o
);
  import uhv_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic [1:0] digits;
    logic [1:0] dots;
    logic       alive;
  } quad_t;

  typedef enum logic [5:0] {
    FUT_START = 6'b000001,
    FUT_V     = 6'b000010,
    FUT_HEX   = 6'b000100,
    FUT_DOT   = 6'b001000,
    FUT_TAIL  = 6'b010000,
    FUT_DEAD  = 6'b100000
  } fut_e;

  typedef enum logic [3:0] {
    NM_PLAIN = 4'b0001,
    NM_PCT1  = 4'b0010,
    NM_PCT2  = 4'b0100,
    NM_DEAD  = 4'b1000
  } name_e;

  typedef struct packed {
    logic [1:0] char_count;
    quad_t      host_quad;
    quad_t      tail_quad;
    logic [2:0] group_digits;
    logic [3:0] group_count;
    logic       compressed;
    logic [1:0] colon_run;
    logic       v6_alive;
    logic       v6_tail;
    fut_e       fut;
    name_e      name;
  } rec_t;

  localparam quad_t QuadClear = '{value: 8'd0, digits: 2'd0, dots: 2'd0, alive: 1'b1};
  localparam rec_t  RecClear  = '{
    char_count: 2'd0, host_quad: QuadClear, tail_quad: QuadClear,
    group_digits: 3'd0, group_count: 4'd0, compressed: 1'b0, colon_run: 2'd0,
    v6_alive: 1'b1, v6_tail: 1'b0, fut: FUT_START, name: NM_PLAIN};

  function automatic quad_t quad_feed(quad_t q, cls_t c);
    quad_t       r;
    logic [11:0] nv;
    r  = q;
    nv = 12'(q.value) * 12'd10 + 12'(c.digit);
    if (q.alive) begin
      if (c.is_digit) begin
        if (q.digits == 2'd1 && q.value == 8'd0) begin
          r.alive = 1'b0;
        end else if (nv >= 12'd256) begin
          r.alive = 1'b0;
        end else begin
          r.value = nv[7:0];
          if (q.digits != 2'd3) r.digits = q.digits + 2'd1;
        end
      end else if (c.is_dot) begin
        if (q.digits == 2'd0 || q.dots == 2'd3) begin
          r.alive = 1'b0;
        end else begin
          r.dots   = q.dots + 2'd1;
          r.value  = 8'd0;
          r.digits = 2'd0;
        end
      end else begin
        r.alive = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic quad_done(quad_t q);
    return q.alive && q.digits != 2'd0 && q.dots == 2'd3;
  endfunction

  rec_t      st_q, st_d, fed;
  cls_t      c;
  logic      take;
  logic      v6_ok;
  logic [3:0] total;
  kind_e     kind;
  logic      out_valid_q, out_valid_d;
  out_data_t out_data_q, out_data_d;
  quad_t     tq;

  assign c = entry_i.cls;

  // next state after feeding the entry byte
  always_comb begin
    fed = st_q;
    tq  = quad_feed(st_q.tail_quad, c);
    if (entry_i.has_char) begin
      if (st_q.char_count != 2'd3) fed.char_count = st_q.char_count + 2'd1;
      fed.host_quad = quad_feed(st_q.host_quad, c);

      // ipv6
      if (st_q.v6_alive) begin
        if (st_q.v6_tail) begin
          fed.tail_quad = tq;
          if (!tq.alive) fed.v6_alive = 1'b0;
        end else if (c.is_hex) begin
          if ((st_q.colon_run == 2'd1 && st_q.group_count == 4'd0) ||
              st_q.group_digits >= 3'd4) begin
            fed.v6_alive = 1'b0;
          end else begin
            fed.group_digits = st_q.group_digits + 3'd1;
            fed.colon_run    = 2'd0;
            fed.tail_quad    = tq;
          end
        end else if (c.is_colon) begin
          if (st_q.colon_run == 2'd0) begin
            if (st_q.group_digits != 3'd0 && st_q.group_count >= 4'd7) begin
              fed.v6_alive = 1'b0;
            end else begin
              if (st_q.group_digits != 3'd0) begin
                fed.group_count  = st_q.group_count + 4'd1;
                fed.group_digits = 3'd0;
              end
              fed.colon_run = 2'd1;
              fed.tail_quad = QuadClear;
            end
          end else if (st_q.colon_run == 2'd1 && !st_q.compressed) begin
            fed.compressed = 1'b1;
            fed.colon_run  = 2'd2;
          end else begin
            fed.v6_alive = 1'b0;
          end
        end else if (c.is_dot) begin
          fed.tail_quad = tq;
          if (!tq.alive) fed.v6_alive = 1'b0;
          else fed.v6_tail = 1'b1;
        end else begin
          fed.v6_alive = 1'b0;
        end
      end

      // ipvfuture
      case (st_q.fut)
        FUT_START: fed.fut = c.is_v ? FUT_V : FUT_DEAD;
        FUT_V:     fed.fut = c.is_hex ? FUT_HEX : FUT_DEAD;
        FUT_HEX: begin
          if (c.is_dot) fed.fut = FUT_DOT;
          else if (!c.is_hex) fed.fut = FUT_DEAD;
        end
        FUT_DOT, FUT_TAIL:
          fed.fut = (c.is_unres || c.is_sub || c.is_colon) ? FUT_TAIL : FUT_DEAD;
        default:   fed.fut = FUT_DEAD;
      endcase

      // reg-name with escapes
      case (st_q.name)
        NM_PLAIN: begin
          if (c.is_pct) fed.name = NM_PCT1;
          else if (!c.is_unres && !c.is_sub) fed.name = NM_DEAD;
        end
        NM_PCT1: fed.name = c.is_hex ? NM_PCT2 : NM_DEAD;
        NM_PCT2: fed.name = c.is_hex ? NM_PLAIN : NM_DEAD;
        default: fed.name = NM_DEAD;
      endcase
    end
  end

  // final judgement on the fed state
  always_comb begin
    v6_ok = 1'b0;
    total = 4'd0;
    if (fed.v6_alive) begin
      if (fed.v6_tail) begin
        v6_ok = quad_done(fed.tail_quad);
        total = fed.group_count + 4'd2;
      end else begin
        v6_ok = !(fed.colon_run == 2'd1 ||
                  (fed.colon_run == 2'd0 && fed.group_digits == 3'd0));
        total = fed.group_count + {3'd0, fed.group_digits != 3'd0};
      end
      v6_ok = v6_ok && (fed.compressed ? (total <= 4'd7) : (total == 4'd8));
    end
    if (fed.char_count == 2'd0)         kind = KIND_EMPTY;
    else if (quad_done(fed.host_quad))  kind = KIND_IPV4;
    else if (v6_ok)                     kind = KIND_IPV6;
    else if (fed.fut == FUT_TAIL)       kind = KIND_FUTURE;
    else if (fed.name == NM_PLAIN)      kind = KIND_NAME;
    else                                kind = KIND_INVALID;
  end

  // a last entry needs the output register free or draining
  assign take  = !empty_i && (!entry_i.last || !out_valid_q || out_ready_i);
  assign pop_o = take;

  always_comb begin
    st_d        = st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if (take) begin
      st_d = entry_i.last ? RecClear : fed;
      if (entry_i.last) begin
        out_valid_d          = 1'b1;
        out_data_d.valid_res = (kind != KIND_INVALID);
        out_data_d.host_kind = kind;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= RecClear;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sv/uri_host_validator_core.sv =====
// ----------------------------------------------------------------------------
// uri_host_validator_core
// URI host syntax checker: one host byte per transfer, one verdict per host.
// ----------------------------------------------------------------------------
// verdict path: the transfer marked last goes through the queue write, then
//   the output register, and its verdict is held back further while
//   older entries sit in the queue or an older verdict is stalled
// throughput: one input transfer per cycle while the queue is not full; the
//   recognizer registers in the back end update on each entry they take
// reset: asynchronous, active low; clears the queue, all recognizers and
//   the output valid, the block is ready in the first cycle after reset
module uri_host_validator_core #(
  parameter int QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  uhv_pkg::in_data_t  in_data_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output uhv_pkg::out_data_t out_data_o
);
  import uhv_pkg::*;

  // queue interface between front and back
  entry_t wr_entry, rd_entry;
  logic   push, pop, q_empty, q_full;

  // front end: byte classification, drops empty items that are not last
  uhv_classify u_classify (
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .full_i     (q_full),
    .in_ready_o (in_ready_o),
    .push_o     (push),
    .entry_o    (wr_entry)
  );

  // short queue so front and back stall on their own
  uhv_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_entry),
    .pop_i   (pop),
    .rdata_o (rd_entry),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // back end: recognizers and output register; a non-last entry always
  // drains, a last entry waits only while an older verdict is stalled
  uhv_recognize u_recognize (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (rd_entry),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/uhv_checker.sv =====
// ----------------------------------------------------------------------------
// uhv_checker
// Port-level checks of the URI host validator, bound to the top level.
// ----------------------------------------------------------------------------
module uhv_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input uhv_pkg::in_data_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input uhv_pkg::out_data_t out_data_o
);
  import uhv_pkg::*;

  // a stalled verdict holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transfer changed");

  // valid flag agrees with the kind code
  a_flag_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.valid_res == (out_data_o.host_kind != KIND_INVALID)))
    else $error("valid_res disagrees with host_kind");

  // kind code is in range
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.host_kind <= KIND_NAME))
    else $error("host_kind out of range");

  // a waiting input transfer holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input transfer changed");

endmodule

bind uri_host_validator_core uhv_checker u_uhv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== bench/uri_host_validator_core_tb.sv =====
// ----------------------------------------------------------------------------
// uri_host_validator_core_tb
// Self-checking bench for the URI host validator. Host strings are streamed
// one byte per transfer, a scoreboard class tracks the host recognizers on
// every accepted transfer and checks each verdict against its own prediction.
// Random gaps are applied on the input side and random stalls on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uri_host_validator_core_tb;
  import uhv_pkg::*;

  // phases of the ipvfuture recognizer
  localparam int FutStart = 0;
  localparam int FutTag   = 1;
  localparam int FutHex   = 2;
  localparam int FutDot   = 3;
  localparam int FutTail  = 4;
  localparam int FutDead  = 7;
  // phases of the registered-name escape recognizer
  localparam int NameOpen = 0;
  localparam int NamePct  = 1;
  localparam int NameHex1 = 2;
  localparam int NameDead = 7;

  localparam int ItemTarget  = 900;
  localparam int ReportLimit = 10;
  localparam int DrainCycles = 8;

  // character pools for host generation
  localparam string HexSet  = "0123456789abcdefABCDEF";
  localparam string NameSet = "abcxyzABCXYZ0189-._~!$&'()*+,;=";
  localparam string FutSet  = "azAZ09-._~!$&'()*+,;=:";

  // state of one dotted-quad recognizer
  typedef struct {
    int val;
    int digs;
    int dots;
    bit live;
  } quad_t;

  // --------------------------------------------------------------------------
  // verdict scoreboard: predicts one verdict per host, checks in order
  // --------------------------------------------------------------------------
  class host_verdict_sb;
    out_data_t pending[$];
    int        faults;
    int        seen;
    quad_t     whole_q;
    quad_t     tail_q;
    int        grp_digits;
    int        grp_count;
    int        colon_cnt;
    bit        dbl_colon;
    bit        v6_live;
    bit        v6_tail;
    int        fut_ph;
    int        name_ph;

    function new();
      faults = 0;
      clear_host();
    endfunction

    function bit is_dig(byte unsigned c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_hexd(byte unsigned c);
      return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function bit is_unres(byte unsigned c);
      return is_dig(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             c == "-" || c == "." || c == "_" || c == "~";
    endfunction

    function bit is_subd(byte unsigned c);
      return c == "!" || c == "$" || c == "&" || c == "'" || c == "(" ||
             c == ")" || c == "*" || c == "+" || c == "," || c == ";" ||
             c == "=";
    endfunction

    function quad_t quad_fresh();
      quad_t q;
      q.val  = 0;
      q.digs = 0;
      q.dots = 0;
      q.live = 1'b1;
      return q;
    endfunction

    function quad_t quad_step(quad_t q, byte unsigned c);
      int nv;
      if (!q.live) return q;
      if (is_dig(c)) begin
        // a zero octet may not be followed by more digits
        if (q.digs == 1 && q.val == 0) begin
          q.live = 1'b0;
          return q;
        end
        nv = q.val * 10 + (c - "0");
        if (nv >= 256) begin
          q.live = 1'b0;
          return q;
        end
        q.val = nv;
        if (q.digs < 3) q.digs++;
      end else if (c == ".") begin
        if (q.digs == 0 || q.dots == 3) begin
          q.live = 1'b0;
          return q;
        end
        q.dots++;
        q.val  = 0;
        q.digs = 0;
      end else begin
        q.live = 1'b0;
      end
      return q;
    endfunction

    function bit quad_ok(quad_t q);
      return q.live && q.digs > 0 && q.dots == 3;
    endfunction

    function void clear_host();
      seen       = 0;
      whole_q    = quad_fresh();
      tail_q     = quad_fresh();
      grp_digits = 0;
      grp_count  = 0;
      colon_cnt  = 0;
      dbl_colon  = 1'b0;
      v6_live    = 1'b1;
      v6_tail    = 1'b0;
      fut_ph     = FutStart;
      name_ph    = NameOpen;
    endfunction

    function void v6_step(byte unsigned c);
      if (!v6_live) return;
      if (v6_tail) begin
        tail_q = quad_step(tail_q, c);
        if (!tail_q.live) v6_live = 1'b0;
        return;
      end
      if (is_hexd(c)) begin
        if ((colon_cnt == 1 && grp_count == 0) || grp_digits >= 4) begin
          v6_live = 1'b0;
          return;
        end
        grp_digits++;
        colon_cnt = 0;
        tail_q = quad_step(tail_q, c);
      end else if (c == ":") begin
        if (colon_cnt == 0) begin
          if (grp_digits > 0) begin
            if (grp_count >= 7) begin
              v6_live = 1'b0;
              return;
            end
            grp_count++;
            grp_digits = 0;
          end
          colon_cnt = 1;
          tail_q = quad_fresh();
        end else if (colon_cnt == 1 && !dbl_colon) begin
          dbl_colon = 1'b1;
          colon_cnt = 2;
        end else begin
          v6_live = 1'b0;
        end
      end else if (c == ".") begin
        tail_q = quad_step(tail_q, c);
        if (!tail_q.live) v6_live = 1'b0;
        else v6_tail = 1'b1;
      end else begin
        v6_live = 1'b0;
      end
    endfunction

    function bit v6_ok();
      int total;
      if (!v6_live) return 1'b0;
      if (v6_tail) begin
        if (!quad_ok(tail_q)) return 1'b0;
        total = grp_count + 2;
      end else begin
        if (colon_cnt == 1 || (colon_cnt == 0 && grp_digits == 0)) return 1'b0;
        total = grp_count + ((grp_digits > 0) ? 1 : 0);
      end
      return dbl_colon ? (total <= 7) : (total == 8);
    endfunction

    function void fut_step(byte unsigned c);
      case (fut_ph)
        FutStart: fut_ph = (c == "v") ? FutTag : FutDead;
        FutTag:   fut_ph = is_hexd(c) ? FutHex : FutDead;
        FutHex: begin
          if (c == ".") fut_ph = FutDot;
          else if (!is_hexd(c)) fut_ph = FutDead;
        end
        FutDot, FutTail: begin
          fut_ph = (is_unres(c) || is_subd(c) || c == ":") ? FutTail : FutDead;
        end
        default: fut_ph = FutDead;
      endcase
    endfunction

    function void name_step(byte unsigned c);
      case (name_ph)
        NameOpen: begin
          if (c == "%") name_ph = NamePct;
          else if (!is_unres(c) && !is_subd(c)) name_ph = NameDead;
        end
        NamePct:  name_ph = is_hexd(c) ? NameHex1 : NameDead;
        NameHex1: name_ph = is_hexd(c) ? NameOpen : NameDead;
        default:  name_ph = NameDead;
      endcase
    endfunction

    // accepted input transfer: advance the recognizers, queue a verdict on last
    function void note_item(in_data_t d);
      kind_e     k;
      out_data_t v;
      if (d.has_char) begin
        if (seen < 3) seen++;
        whole_q = quad_step(whole_q, d.ch);
        v6_step(d.ch);
        fut_step(d.ch);
        name_step(d.ch);
      end
      if (!d.last) return;
      if (seen == 0) k = KIND_EMPTY;
      else if (quad_ok(whole_q)) k = KIND_IPV4;
      else if (v6_ok()) k = KIND_IPV6;
      else if (fut_ph == FutTail) k = KIND_FUTURE;
      else if (name_ph == NameOpen) k = KIND_NAME;
      else k = KIND_INVALID;
      v.valid_res = (k != KIND_INVALID);
      v.host_kind = k;
      pending.push_back(v);
      clear_host();
    endfunction

    function void flag(string what, int want, int got);
      faults++;
      if (faults <= ReportLimit)
        $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
    endfunction

    // accepted output transfer: compare with the oldest predicted verdict
    function void check_verdict(out_data_t got);
      out_data_t want;
      if (pending.size() == 0) begin
        flag("unexpected verdict, kind", -1, int'(got.host_kind));
        return;
      end
      want = pending.pop_front();
      if (got.valid_res !== want.valid_res)
        flag("valid_res", int'(want.valid_res), int'(got.valid_res));
      if (got.host_kind !== want.host_kind)
        flag("host_kind", int'(want.host_kind), int'(got.host_kind));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and dut
  // --------------------------------------------------------------------------
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_data_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_data_t out_data_o;

  host_verdict_sb verdicts;
  byte unsigned   host_q[$];   // bytes of the host being built
  int             items_sent;  // byte transfers plus closing transfers
  bit             calm;        // when set, neither side idles

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  uri_host_validator_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // idle length: mostly none or short, now and then a long one
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // host string builders
  // --------------------------------------------------------------------------
  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) host_q.push_back(s[i]);
  endfunction

  function automatic string hex_group(int n);
    string s;
    s = "";
    repeat (n) s = {s, string'(HexSet[$urandom_range(0, HexSet.len() - 1)])};
    return s;
  endfunction

  // dotted quad, mostly well formed; sometimes a leading zero, an octet
  // above 255, an empty octet or the wrong number of octets
  function automatic string quad_str();
    string s;
    int    n;
    s = "";
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 5) : 4;
    for (int i = 0; i < n; i++) begin
      if (i > 0) s = {s, "."};
      case ($urandom_range(0, 19))
        0: s = {s, "0", $sformatf("%0d", $urandom_range(0, 99))};
        1: s = {s, $sformatf("%0d", $urandom_range(256, 999))};
        2: ;
        3: s = {s, "0"};
        4: s = {s, "255"};
        default: s = {s, $sformatf("%0d", $urandom_range(0, 255))};
      endcase
    end
    return s;
  endfunction

  // ipv6 with or without "::", optionally ending in a dotted quad;
  // group count and group width are pushed past the limits now and then
  function automatic string v6_str();
    string s;
    bit    tail;
    bit    comp;
    int    total;
    int    words;
    int    left;
    tail  = ($urandom_range(0, 3) == 0);
    comp  = ($urandom_range(0, 1) == 1);
    total = comp ? $urandom_range(0, 7) : 8;
    if ($urandom_range(0, 9) == 0) total++;
    words = tail ? total - 2 : total;
    if (words < 0) words = 0;
    left = comp ? $urandom_range(0, words) : words;
    s = "";
    for (int i = 0; i < words; i++) begin
      if (comp && i == left) s = {s, "::"};
      else if (i > 0) s = {s, ":"};
      s = {s, hex_group(($urandom_range(0, 9) == 0) ? 5 : $urandom_range(1, 4))};
    end
    if (comp && left == words) s = {s, "::"};
    if (tail) begin
      if (words > 0 && !(comp && left == words)) s = {s, ":"};
      s = {s, quad_str()};
    end
    return s;
  endfunction

  // ipvfuture, sometimes with an upper-case tag, no dot or an empty tail
  function automatic string future_str();
    string s;
    s = ($urandom_range(0, 9) == 0) ? "V" : "v";
    s = {s, hex_group($urandom_range(1, 3))};
    if ($urandom_range(0, 9) != 0) s = {s, "."};
    repeat ($urandom_range(0, 5))
      s = {s, string'(FutSet[$urandom_range(0, FutSet.len() - 1)])};
    return s;
  endfunction

  // registered name with escapes, some of them broken or cut short
  function automatic string name_str();
    string s;
    s = "";
    repeat ($urandom_range(1, 10)) begin
      if ($urandom_range(0, 6) == 0) begin
        s = {s, "%", hex_group(1)};
        case ($urandom_range(0, 5))
          0: s = {s, "g"};
          1: ;
          default: s = {s, hex_group(1)};
        endcase
      end else begin
        s = {s, string'(NameSet[$urandom_range(0, NameSet.len() - 1)])};
      end
    end
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // input driver
  // --------------------------------------------------------------------------
  // one transfer: drive at the falling edge, hold until accepted, then idle
  task automatic feed_item(in_data_t d);
    int g;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    verdicts.note_item(d);
    g = idle_len();
    if (g > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  // stream host_q; the host closes on its last byte or on a byte-less transfer,
  // with byte-less filler transfers sprinkled in on request
  task automatic send_host(bit sep_last, bit sprinkle);
    in_data_t d;
    for (int i = 0; i < host_q.size(); i++) begin
      if (sprinkle && $urandom_range(0, 19) == 0) begin
        d.ch       = 8'($urandom);
        d.has_char = 1'b0;
        d.last     = 1'b0;
        feed_item(d);
      end
      d.ch       = host_q[i];
      d.has_char = 1'b1;
      d.last     = !sep_last && (i == host_q.size() - 1);
      feed_item(d);
      items_sent++;
    end
    if (sep_last || host_q.size() == 0) begin
      d.ch       = 8'($urandom);
      d.has_char = 1'b0;
      d.last     = 1'b1;
      feed_item(d);
      items_sent++;
    end
  endtask

  task automatic send_text(string s, bit sep_last);
    host_q.delete();
    push_str(s);
    send_host(sep_last, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // output side: ready in runs, broken up by random stalls
  // --------------------------------------------------------------------------
  initial begin
    int run;
    int stall;
    @(posedge rst_ni);
    forever begin
      run   = $urandom_range(1, 16);
      stall = idle_len();
      @(negedge clk_i) out_ready_i <= 1'b1;
      repeat (run - 1) @(negedge clk_i);
      if (stall > 0) begin
        @(negedge clk_i) out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
    end
  end

  // every output transfer is checked at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) verdicts.check_verdict(out_data_o);
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_data_t d;
    int       r;
    verdicts   = new();
    items_sent = 0;
    calm       = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: empty host
    send_text("", 1'b1);
    // filler transfer is ignored, then a bare "::" closed by a byte-less last
    d.ch       = 8'h5a;
    d.has_char = 1'b0;
    d.last     = 1'b0;
    feed_item(d);
    send_text("::", 1'b1);
    // ipvfuture, then the same with an upper-case tag (falls back to name)
    send_text("v1.a", 1'b0);
    send_text("V1.a", 1'b0);
    // bytes outside every character set, extremes of the byte range
    host_q = {8'h00};
    send_host(1'b0, 1'b0);
    host_q = {8'hff};
    send_host(1'b0, 1'b0);
    // all-zero quad and an escape
    send_text("0.0.0.0", 1'b0);
    send_text("%4F", 1'b0);

    // random hosts, mostly well formed with random content
    while (items_sent < ItemTarget) begin
      if ($urandom_range(0, 9) == 0) calm = !calm;
      host_q.delete();
      r = $urandom_range(0, 99);
      if (r < 20) push_str(quad_str());
      else if (r < 50) push_str(v6_str());
      else if (r < 62) push_str(future_str());
      else if (r < 82) push_str(name_str());
      else if (r < 94) repeat ($urandom_range(1, 6)) host_q.push_back(8'($urandom));
      // otherwise an empty host
      // occasionally damage one byte of the host
      if (host_q.size() > 0 && $urandom_range(0, 6) == 0)
        host_q[$urandom_range(0, host_q.size() - 1)] = 8'($urandom);
      send_host($urandom_range(0, 3) == 0, 1'b1);
    end
    @(negedge clk_i) in_valid_i <= 1'b0;
    calm = 1'b0;

    // drain every predicted verdict, then let the pipeline settle
    while (verdicts.pending.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (verdicts.faults == 0 && verdicts.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/uhv_pkg.sv
sv/uhv_classify.sv
sv/uhv_fifo.sv
sv/uhv_recognize.sv
sv/uri_host_validator_core.sv
sv/uhv_checker.sv
bench/uri_host_validator_core_tb.sv
